@@ hw/rtl/tfcc_pkg.sv @@
// ----------------------------------------------------------------------------
// tfcc_pkg
// Shared constants, types and helpers for the triggered four-channel capture.
// ----------------------------------------------------------------------------
`default_nettype none

package tfcc_pkg;

  localparam int DEPTH       = 512;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int FILL_W      = $clog2(DEPTH + 1);
  localparam int CNT_W       = 24;
  localparam int RAM_W       = 4 * SAMPLE_BITS;
  localparam int CFG_DATA_W  = 24;
  localparam int HYST_STEPS  = 3;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // trigger source codes
  localparam logic [2:0] SRC_EXT = 3'd0;
  localparam logic [2:0] SRC_A   = 3'd1;
  localparam logic [2:0] SRC_B   = 3'd2;
  localparam logic [2:0] SRC_C   = 3'd3;
  localparam logic [2:0] SRC_D   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_DECIMATION = 3'd0;
  localparam logic [2:0] REG_HOLDOFF    = 3'd1;
  localparam logic [2:0] REG_TRIG_SRC   = 3'd2;
  localparam logic [2:0] REG_TRIG_LEVEL = 3'd3;
  localparam logic [2:0] REG_ZERO_MASK  = 3'd4;

  typedef struct packed {
    logic [15:0]        decimation;
    logic [23:0]        holdoff_samples;
    logic [2:0]         trigger_source;
    logic signed [15:0] trigger_level;
    logic [3:0]         zero_mask;
  } cfg_t;

  // per-item result fields handed from the acquisition stage to the output stage
  typedef struct packed {
    logic       rd_ok;
    logic [9:0] write_position;
    logic       frozen;
    logic       rearmed;
  } res_t;

  function automatic logic [SAMPLE_BITS-1:0] to_store(input logic [15:0] v);
    logic signed [31:0] x;
    x = 32'(signed'(v));
    return x[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [15:0] from_store(input logic [SAMPLE_BITS-1:0] s);
    logic signed [31:0] x;
    x = 32'(signed'(s));
    return x[15:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tfcc_in_if.sv @@
// ----------------------------------------------------------------------------
// tfcc_in_if
// Input word channel: sample or read command with its fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfcc_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] chan_a;
  logic signed [15:0] chan_b;
  logic signed [15:0] chan_c;
  logic signed [15:0] chan_d;
  logic signed [15:0] ext_trig;
  logic [4:0]         connected_mask;
  logic               freeze_press;
  logic [8:0]         read_index;

  modport source (
    output valid, command, chan_a, chan_b, chan_c, chan_d, ext_trig,
           connected_mask, freeze_press, read_index,
    input  ready
  );
  modport sink (
    input  valid, command, chan_a, chan_b, chan_c, chan_d, ext_trig,
           connected_mask, freeze_press, read_index,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/tfcc_out_if.sv @@
// ----------------------------------------------------------------------------
// tfcc_out_if
// Result word channel: read data and capture status.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] read_a;
  logic signed [15:0] read_b;
  logic signed [15:0] read_c;
  logic signed [15:0] read_d;
  logic [9:0]         write_position;
  logic               frozen;
  logic               rearmed;

  modport source (
    output valid, read_a, read_b, read_c, read_d, write_position, frozen, rearmed,
    input  ready
  );
  modport sink (
    input  valid, read_a, read_b, read_c, read_d, write_position, frozen, rearmed,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/tfcc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// tfcc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tfcc_ram.sv @@
// ----------------------------------------------------------------------------
// tfcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tfcc_cfg.sv @@
// ----------------------------------------------------------------------------
// tfcc_cfg
// Configuration register bank, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcc_cfg (
  input  wire logic     clk,
  input  wire logic     rst_n,
  tfcc_cfg_if.sink      cfg_port,
  output tfcc_pkg::cfg_t cfg
);

  tfcc_pkg::cfg_t cfg_r;

  assign cfg_port.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decimation      <= 16'd3;
      cfg_r.holdoff_samples <= 24'd0;
      cfg_r.trigger_source  <= tfcc_pkg::SRC_A;
      cfg_r.trigger_level   <= 16'sd0;
      cfg_r.zero_mask       <= 4'd0;
    end else if (cfg_port.valid) begin
      case (cfg_port.index)
        tfcc_pkg::REG_DECIMATION: cfg_r.decimation      <= cfg_port.data[15:0];
        tfcc_pkg::REG_HOLDOFF:    cfg_r.holdoff_samples <= cfg_port.data[23:0];
        tfcc_pkg::REG_TRIG_SRC:   cfg_r.trigger_source  <= cfg_port.data[2:0];
        tfcc_pkg::REG_TRIG_LEVEL: cfg_r.trigger_level   <= signed'(cfg_port.data[15:0]);
        tfcc_pkg::REG_ZERO_MASK:  cfg_r.zero_mask       <= cfg_port.data[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tfcc_acq.sv @@
// ----------------------------------------------------------------------------
// tfcc_acq
// Input register plus acquisition state: decimation, fill, freeze, trigger
// detector and rearm; issues store writes and read requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcc_acq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tfcc_in_if.sink                            in_port,
  input  wire tfcc_pkg::cfg_t                cfg,
  input  wire logic                          res_ready,
  output logic                               res_valid,
  output tfcc_pkg::res_t                     res,
  output logic                               ram_we,
  output logic [tfcc_pkg::ADDR_W-1:0]        ram_waddr,
  output logic [tfcc_pkg::RAM_W-1:0]         ram_wdata,
  output logic                               ram_re,
  output logic [tfcc_pkg::ADDR_W-1:0]        ram_raddr
);

  // input register
  logic               s1_valid_r;
  logic               cmd_r;
  logic signed [15:0] chan_a_r, chan_b_r, chan_c_r, chan_d_r, ext_r;
  logic [4:0]         conn_r;
  logic               press_r;
  logic [8:0]         idx_r;

  // capture state
  logic [tfcc_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [tfcc_pkg::FILL_W-1:0] hwm_r, hwm_nxt;
  logic [tfcc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        freeze_r, freeze_nxt;
  logic                        prev_r, prev_nxt;
  logic                        trig_r, trig_nxt;

  logic                        s1_adv;
  logic                        in_acc;
  logic                        rearm;
  logic                        src_conn;
  logic                        src_zero;
  logic signed [15:0]          src_val;
  logic signed [16:0]          diff;
  logic [tfcc_pkg::CNT_W-1:0]  cinc;
  logic [31:0]                 idx_ext;
  logic [31:0]                 pos_ext;

  assign s1_adv        = s1_valid_r && res_ready;
  assign in_port.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_port.valid && in_port.ready;
  assign res_valid     = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_port.command;
      chan_a_r <= in_port.chan_a;
      chan_b_r <= in_port.chan_b;
      chan_c_r <= in_port.chan_c;
      chan_d_r <= in_port.chan_d;
      ext_r    <= in_port.ext_trig;
      conn_r   <= in_port.connected_mask;
      press_r  <= in_port.freeze_press;
      idx_r    <= in_port.read_index;
    end
  end

  // selected trigger source
  always_comb begin
    src_conn = 1'b0;
    src_zero = 1'b0;
    src_val  = ext_r;
    case (cfg.trigger_source)
      tfcc_pkg::SRC_EXT: begin
        src_conn = conn_r[0];
      end
      tfcc_pkg::SRC_A: begin
        src_conn = conn_r[1];
        src_zero = cfg.zero_mask[0];
        src_val  = chan_a_r;
      end
      tfcc_pkg::SRC_B: begin
        src_conn = conn_r[2];
        src_zero = cfg.zero_mask[1];
        src_val  = chan_b_r;
      end
      tfcc_pkg::SRC_C: begin
        src_conn = conn_r[3];
        src_zero = cfg.zero_mask[2];
        src_val  = chan_c_r;
      end
      tfcc_pkg::SRC_D: begin
        src_conn = conn_r[4];
        src_zero = cfg.zero_mask[3];
        src_val  = chan_d_r;
      end
      default: begin
        // out-of-range source behaves as unconnected
        src_conn = 1'b0;
      end
    endcase
  end

  assign diff = 17'(src_val) - 17'(cfg.trigger_level);

  always_comb begin
    fill_nxt   = fill_r;
    hwm_nxt    = hwm_r;
    cnt_nxt    = cnt_r;
    freeze_nxt = freeze_r;
    prev_nxt   = prev_r;
    trig_nxt   = trig_r;
    ram_we     = 1'b0;
    rearm      = 1'b0;
    cinc       = cnt_r;
    if (s1_adv && cmd_r == tfcc_pkg::CMD_SAMPLE) begin
      prev_nxt = press_r;
      if (press_r && !prev_r) begin
        freeze_nxt = !freeze_r;
      end
      if (fill_r < tfcc_pkg::FILL_FULL) begin
        cinc = (cnt_r == tfcc_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;
        if (cinc > tfcc_pkg::CNT_W'(cfg.decimation)) begin
          cnt_nxt  = '0;
          ram_we   = 1'b1;
          fill_nxt = fill_r + 1'b1;
          // writes run in order from zero, so the high-water mark rises only while fill is at it
          if (fill_r == hwm_r) begin
            hwm_nxt = hwm_r + 1'b1;
          end
        end else begin
          cnt_nxt = cinc;
        end
      end
      if (fill_nxt == tfcc_pkg::FILL_FULL && !freeze_nxt) begin
        if (!src_conn || src_zero) begin
          rearm = 1'b1;
        end else begin
          cnt_nxt = (cnt_nxt == tfcc_pkg::CNT_MAX) ? cnt_nxt : cnt_nxt + 1'b1;
          if (trig_r) begin
            if (diff <= 17'sd0) begin
              trig_nxt = 1'b0;
            end
          end else if (diff >= signed'(17'(tfcc_pkg::HYST_STEPS))) begin
            trig_nxt = 1'b1;
            rearm    = 1'b1;
          end
          if (cnt_nxt >= cfg.holdoff_samples) begin
            rearm = 1'b1;
          end
        end
        if (rearm) begin
          trig_nxt = 1'b1;
          fill_nxt = '0;
          cnt_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      hwm_r    <= '0;
      cnt_r    <= '0;
      freeze_r <= 1'b0;
      prev_r   <= 1'b0;
      trig_r   <= 1'b1;
    end else begin
      fill_r   <= fill_nxt;
      hwm_r    <= hwm_nxt;
      cnt_r    <= cnt_nxt;
      freeze_r <= freeze_nxt;
      prev_r   <= prev_nxt;
      trig_r   <= trig_nxt;
    end
  end

  assign ram_waddr = fill_r[tfcc_pkg::ADDR_W-1:0];
  assign ram_wdata = {tfcc_pkg::to_store(chan_a_r), tfcc_pkg::to_store(chan_b_r),
                      tfcc_pkg::to_store(chan_c_r), tfcc_pkg::to_store(chan_d_r)};

  assign idx_ext   = 32'(idx_r);
  assign ram_re    = s1_adv && cmd_r == tfcc_pkg::CMD_READ;
  assign ram_raddr = idx_ext[tfcc_pkg::ADDR_W-1:0];

  assign pos_ext = 32'(fill_nxt);

  always_comb begin
    // never-written entries read as zero
    res.rd_ok          = (cmd_r == tfcc_pkg::CMD_READ) && (idx_ext < 32'(hwm_r));
    res.write_position = pos_ext[9:0];
    res.frozen         = freeze_nxt;
    res.rearmed        = rearm;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= tfcc_pkg::FILL_FULL)
    else $error("fill position beyond depth");

  a_hwm_covers_fill: assert property (@(posedge clk) disable iff (!rst_n)
    hwm_r >= fill_r)
    else $error("high-water mark below fill position");

  a_rearm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    rearm |=> (fill_r == '0 && cnt_r == '0 && trig_r))
    else $error("rearm did not restart capture");

  a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && cmd_r == tfcc_pkg::CMD_READ) |=>
      ($stable(fill_r) && $stable(cnt_r) && $stable(freeze_r) && $stable(prev_r)))
    else $error("read command changed capture state");

endmodule

`default_nettype wire

@@ hw/rtl/tfcc_out.sv @@
// ----------------------------------------------------------------------------
// tfcc_out
// Result register: holds status fields beside the registered store read
// data and presents the result word until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcc_out (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       res_valid,
  input  wire tfcc_pkg::res_t             res,
  output logic                            res_ready,
  input  wire logic [tfcc_pkg::RAM_W-1:0] ram_rdata,
  tfcc_out_if.source                      out_port
);

  localparam int SB = tfcc_pkg::SAMPLE_BITS;

  logic           s2_valid_r;
  tfcc_pkg::res_t res_r;

  assign res_ready = !s2_valid_r || out_port.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (res_valid) begin
      s2_valid_r <= 1'b1;
    end else if (out_port.ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_port.valid          = s2_valid_r;
  assign out_port.read_a         = res_r.rd_ok ?
                                   tfcc_pkg::from_store(ram_rdata[4*SB-1:3*SB]) : '0;
  assign out_port.read_b         = res_r.rd_ok ?
                                   tfcc_pkg::from_store(ram_rdata[3*SB-1:2*SB]) : '0;
  assign out_port.read_c         = res_r.rd_ok ?
                                   tfcc_pkg::from_store(ram_rdata[2*SB-1:SB]) : '0;
  assign out_port.read_d         = res_r.rd_ok ?
                                   tfcc_pkg::from_store(ram_rdata[SB-1:0]) : '0;
  assign out_port.write_position = res_r.write_position;
  assign out_port.frozen         = res_r.frozen;
  assign out_port.rearmed        = res_r.rearmed;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_port.ready) |-> !res_valid)
    else $error("result overwritten while stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_port.ready) |=> (s2_valid_r && $stable(res_r)))
    else $error("stalled result lost");

  a_rearm_only_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.rd_ok) |-> !res.rearmed)
    else $error("read command reported a rearm");

endmodule

`default_nettype wire

@@ hw/rtl/triggered_four_channel_capture_top.sv @@
// ----------------------------------------------------------------------------
// triggered_four_channel_capture_top
// Four-channel triggered capture: decimated store fill, freeze, rearm on
// trigger crossing, hold-off or lost source, and indexed read-back.
// ----------------------------------------------------------------------------
// a word passes the input register, then the result register beside the store's
// read register; either can hold it while the output stalls
// throughput: one word per cycle while the output is not stalled; the store
// takes one write and one read a cycle
// reset (rst_n low, synchronous): registers to defaults, capture empty, detector high
// no clearing pass: a high-water mark makes never-written entries read as zero
`default_nettype none

module triggered_four_channel_capture_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tfcc_in_if.sink    in_port,
  tfcc_out_if.source out_port,
  tfcc_cfg_if.sink   cfg_port
);

  tfcc_pkg::cfg_t                cfg;
  tfcc_pkg::res_t                res;
  logic                          res_valid;
  logic                          res_ready;
  logic                          ram_we;
  logic [tfcc_pkg::ADDR_W-1:0]   ram_waddr;
  logic [tfcc_pkg::RAM_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [tfcc_pkg::ADDR_W-1:0]   ram_raddr;
  logic [tfcc_pkg::RAM_W-1:0]    ram_rdata;

  tfcc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_port (cfg_port),
    .cfg      (cfg)
  );

  tfcc_acq u_acq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_port   (in_port),
    .cfg       (cfg),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // all four channel stores share one word per entry
  tfcc_ram #(
    .WIDTH (tfcc_pkg::RAM_W),
    .DEPTH (tfcc_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tfcc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .ram_rdata (ram_rdata),
    .out_port  (out_port)
  );

endmodule

`default_nettype wire

@@ tb/tfcc_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// tfcc_tb_pkg
// Word types and the capture tracker: mirrors the stores, fill position,
// freeze and trigger detector, predicts each status word and checks it.
// ----------------------------------------------------------------------------
package tfcc_tb_pkg;
  import tfcc_pkg::*;

  typedef struct packed {
    logic        command;
    logic [15:0] chan_a;
    logic [15:0] chan_b;
    logic [15:0] chan_c;
    logic [15:0] chan_d;
    logic [15:0] ext_trig;
    logic [4:0]  connected_mask;
    logic        freeze_press;
    logic [8:0]  read_index;
  } capture_word_t;

  typedef struct packed {
    logic [15:0] read_a;
    logic [15:0] read_b;
    logic [15:0] read_c;
    logic [15:0] read_d;
    logic [9:0]  write_position;
    logic        frozen;
    logic        rearmed;
  } capture_status_t;

  class capture_tracker;
    logic [15:0] cap_a [DEPTH];
    logic [15:0] cap_b [DEPTH];
    logic [15:0] cap_c [DEPTH];
    logic [15:0] cap_d [DEPTH];
    logic [9:0]  fill;
    logic [23:0] tally;
    bit          frozen;
    bit          btn_prev;
    bit          det_high;
    logic [15:0] decim;
    logic [23:0] holdoff;
    logic [2:0]  src;
    logic [15:0] level;
    logic [3:0]  zmask;
    capture_status_t pending [$];
    int unsigned mismatches;

    function new();
      foreach (cap_a[i]) begin
        cap_a[i] = '0;
        cap_b[i] = '0;
        cap_c[i] = '0;
        cap_d[i] = '0;
      end
      fill       = '0;
      tally      = '0;
      frozen     = 1'b0;
      btn_prev   = 1'b0;
      det_high   = 1'b1;
      decim      = 16'd3;
      holdoff    = '0;
      src        = SRC_A;
      level      = '0;
      zmask      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        REG_DECIMATION: decim   = data[15:0];
        REG_HOLDOFF:    holdoff = data;
        REG_TRIG_SRC:   src     = data[2:0];
        REG_TRIG_LEVEL: level   = data[15:0];
        REG_ZERO_MASK:  zmask   = data[3:0];
        default: ;
      endcase
    endfunction

    function void take_word(capture_word_t w);
      capture_status_t     want;
      bit                  fire;
      bit                  live;
      bit                  gone;
      logic signed [15:0]  probe;
      logic signed [15:0]  thresh;
      int                  diff;
      want  = '0;
      fire  = 1'b0;
      live  = 1'b0;
      gone  = 1'b0;
      probe = '0;
      if (w.command == CMD_READ) begin
        want.read_a = cap_a[w.read_index];
        want.read_b = cap_b[w.read_index];
        want.read_c = cap_c[w.read_index];
        want.read_d = cap_d[w.read_index];
      end else begin
        if (w.freeze_press && !btn_prev) frozen = !frozen;
        btn_prev = w.freeze_press;
        if (fill < DEPTH) begin
          if (tally != CNT_MAX) tally = tally + 1'b1;
          if (tally > decim) begin
            tally             = '0;
            cap_a[fill[8:0]] = w.chan_a;
            cap_b[fill[8:0]] = w.chan_b;
            cap_c[fill[8:0]] = w.chan_c;
            cap_d[fill[8:0]] = w.chan_d;
            fill              = fill + 1'b1;
          end
        end
        // full and running: look for a rearm
        if (fill >= DEPTH && !frozen) begin
          case (src)
            SRC_EXT: begin live = w.connected_mask[0]; probe = w.ext_trig; end
            SRC_A: begin
              live = w.connected_mask[1]; probe = w.chan_a; gone = zmask[0];
            end
            SRC_B: begin
              live = w.connected_mask[2]; probe = w.chan_b; gone = zmask[1];
            end
            SRC_C: begin
              live = w.connected_mask[3]; probe = w.chan_c; gone = zmask[2];
            end
            SRC_D: begin
              live = w.connected_mask[4]; probe = w.chan_d; gone = zmask[3];
            end
            default: live = 1'b0;
          endcase
          if (!live || gone) begin
            fire = 1'b1;
          end else begin
            thresh = level;
            diff   = int'(probe) - int'(thresh);
            if (tally != CNT_MAX) tally = tally + 1'b1;
            // hysteresis: drop at or below the level, fire a few steps above
            if (det_high) begin
              if (diff <= 0) det_high = 1'b0;
            end else if (diff >= HYST_STEPS) begin
              det_high = 1'b1;
              fire     = 1'b1;
            end
            if (!fire && tally >= holdoff) fire = 1'b1;
          end
          if (fire) begin
            det_high = 1'b1;
            fill     = '0;
            tally    = '0;
          end
        end
      end
      want.write_position = fill;
      want.frozen         = frozen;
      want.rearmed        = fire;
      pending.push_back(want);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_status(capture_status_t got);
      capture_status_t want;
      if (pending.size() == 0) begin
        report("status word with no word outstanding");
      end else begin
        want = pending.pop_front();
        if (got.read_a !== want.read_a)
          report($sformatf("read_a %h, predicted %h", got.read_a, want.read_a));
        if (got.read_b !== want.read_b)
          report($sformatf("read_b %h, predicted %h", got.read_b, want.read_b));
        if (got.read_c !== want.read_c)
          report($sformatf("read_c %h, predicted %h", got.read_c, want.read_c));
        if (got.read_d !== want.read_d)
          report($sformatf("read_d %h, predicted %h", got.read_d, want.read_d));
        if (got.write_position !== want.write_position)
          report($sformatf("write_position %0d, predicted %0d",
                           got.write_position, want.write_position));
        if (got.frozen !== want.frozen)
          report($sformatf("frozen %b, predicted %b", got.frozen, want.frozen));
        if (got.rearmed !== want.rearmed)
          report($sformatf("rearmed %b, predicted %b", got.rearmed, want.rearmed));
      end
    endtask
  endclass

endpackage

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives sample and read words into the triggered capture block under
// several register settings and idle patterns, and checks every status word
// against the capture tracker's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tfcc_pkg::*;
  import tfcc_tb_pkg::*;

  typedef struct {
    logic [15:0] decim;
    logic [23:0] hold;
    logic [2:0]  src;
    logic [15:0] level;
    logic [3:0]  zmask;
    int          words;
    bit          swing;
    int          read_pct;
  } phase_t;

  // fill needs 512 captures, so most settings keep decimation at zero
  phase_t plan [6] = '{
    '{16'd0,     24'hFFFFFF, SRC_A,   16'h0000, 4'h0, 580, 1'b1, 10},
    '{16'd0,     24'd24,     SRC_EXT, 16'd1000, 4'h0, 150, 1'b0, 25},
    '{16'hFFFF,  24'd0,      SRC_D,   16'h8000, 4'hF,  50, 1'b1, 20},
    '{16'd0,     24'd0,      SRC_C,   16'h7FFF, 4'h0, 300, 1'b1,  5},
    '{16'd2,     24'd6,      3'd7,    16'hFF38, 4'h5,  60, 1'b1, 20},
    '{16'd0,     24'd300,    SRC_B,   16'h8000, 4'h0, 200, 1'b0, 30}
  };

  logic clk = 1'b0;
  logic rst_n;

  tfcc_in_if  in_if ();
  tfcc_out_if out_if ();
  tfcc_cfg_if cfg_if ();

  triggered_four_channel_capture_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if),
    .cfg_port (cfg_if)
  );

  capture_tracker tracker = new();

  int          send_idle_pct;
  int          recv_stall_pct;
  int          read_pct;
  logic [15:0] cur_level;
  bit          swing;
  bit          btn_level;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      tracker.check_status('{out_if.read_a, out_if.read_b, out_if.read_c, out_if.read_d,
                             out_if.write_position, out_if.frozen, out_if.rearmed});
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // trigger-ish value: mostly near the level so the detector keeps moving
  function automatic logic [15:0] trig_value();
    if ($urandom_range(99) < 20) return 16'($urandom);
    if (swing) return 16'(cur_level + $urandom_range(16) - 8);
    return 16'(cur_level - $urandom_range(40));
  endfunction

  function automatic capture_word_t next_random_word();
    capture_word_t w;
    w.command        = ($urandom_range(99) < read_pct) ? CMD_READ : CMD_SAMPLE;
    w.chan_a         = trig_value();
    w.chan_b         = trig_value();
    w.chan_c         = trig_value();
    w.chan_d         = trig_value();
    w.ext_trig       = trig_value();
    w.connected_mask = ($urandom_range(9) == 0) ? 5'($urandom) : 5'h1F;
    if ($urandom_range(49) == 0) btn_level = !btn_level;
    w.freeze_press   = (w.command == CMD_READ) ? 1'($urandom) : btn_level;
    w.read_index     = 9'($urandom);
    return w;
  endfunction

  // valid stays high across back-to-back words; only an idle cycle lowers it
  task automatic push_word(input capture_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.command        <= w.command;
    in_if.chan_a         <= w.chan_a;
    in_if.chan_b         <= w.chan_b;
    in_if.chan_c         <= w.chan_c;
    in_if.chan_d         <= w.chan_d;
    in_if.ext_trig       <= w.ext_trig;
    in_if.connected_mask <= w.connected_mask;
    in_if.freeze_press   <= w.freeze_press;
    in_if.read_index     <= w.read_index;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    tracker.take_word(w);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    tracker.set_reg(idx, data);
  endtask

  task automatic settle();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    capture_word_t w;
    logic [8:0]    probes [6] = '{9'd0, 9'd1, 9'd2, 9'd511, 9'h155, 9'h0AA};
    int            mode;

    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.command        = CMD_SAMPLE;
    in_if.chan_a         = '0;
    in_if.chan_b         = '0;
    in_if.chan_c         = '0;
    in_if.chan_d         = '0;
    in_if.ext_trig       = '0;
    in_if.connected_mask = '0;
    in_if.freeze_press   = 1'b0;
    in_if.read_index     = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_DECIMATION;
    cfg_if.data          = '0;
    out_if.ready         = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    read_pct             = 10;
    cur_level            = '0;
    swing                = 1'b1;
    btn_level            = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme samples under reset settings, freeze on and off,
    // then reads of written, unwritten and edge indexes
    for (int k = 0; k < 8; k++) begin
      w.command        = CMD_SAMPLE;
      w.chan_a         = k[0] ? 16'h7FFF : 16'h8000;
      w.chan_b         = k[0] ? 16'h8000 : 16'h7FFF;
      w.chan_c         = 16'(k * 16'h1111);
      w.chan_d         = 16'(-k);
      w.ext_trig       = k[1] ? 16'h7FFF : 16'h8000;
      w.connected_mask = k[0] ? 5'h1F : 5'h00;
      w.freeze_press   = (k == 2 || k == 3 || k == 5);
      w.read_index     = 9'($urandom);
      push_word(w);
    end
    foreach (probes[i]) begin
      w            = next_random_word();
      w.command    = CMD_READ;
      w.read_index = probes[i];
      push_word(w);
    end
    in_if.valid <= 1'b0;

    foreach (plan[p]) begin
      settle();
      write_reg(REG_DECIMATION, {8'($urandom), plan[p].decim});
      write_reg(REG_HOLDOFF,    plan[p].hold);
      write_reg(REG_TRIG_SRC,   {21'($urandom), plan[p].src});
      write_reg(REG_TRIG_LEVEL, {8'($urandom), plan[p].level});
      write_reg(REG_ZERO_MASK,  {20'($urandom), plan[p].zmask});
      cfg_if.valid <= 1'b0;
      cur_level = plan[p].level;
      swing     = plan[p].swing;
      read_pct  = plan[p].read_pct;
      mode      = p % 4;
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      repeat (plan[p].words) push_word(next_random_word());
      in_if.valid <= 1'b0;
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
